// File: hw/rtl/bmhpq_pkg.sv
// Shared types and codes for the min-priority queue (sorted key chain).
// No dependencies. Imported by bmhpq_cell and binary_min_heap_priority_queue_core.
package bmhpq_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned OccW = 7;
  localparam int unsigned CapW = 7;

  // Request operation codes
  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } bmhpq_opcode_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } bmhpq_status_e;

  // Register indexes on the configuration port
  localparam logic [1:0] RegCapacityAddr = 2'd0;

  // Operation broadcast to every cell of the chain
  typedef struct packed {
    logic                   ins;
    logic                   ext;
    logic signed [KeyW-1:0] key;
  } bmhpq_op_t;

endpackage

// File: hw/rtl/bmhpq_cell.sv
// One slot of the sorted key chain: holds a key, compares it with the
// broadcast insert key and trades keys with its two neighbors.
// Depends on bmhpq_pkg.
module bmhpq_cell #(
  parameter int unsigned CW  = 7,
  parameter int unsigned IDX = 0
) (
  input  logic                            clk_i,
  input  bmhpq_pkg::bmhpq_op_t            op_i,
  input  logic [CW-1:0]                   count_i,
  input  logic signed [bmhpq_pkg::KeyW-1:0] prev_key_i,
  input  logic                            prev_lt_i,
  input  logic signed [bmhpq_pkg::KeyW-1:0] next_key_i,
  output logic signed [bmhpq_pkg::KeyW-1:0] key_o,
  output logic                            lt_o
);
  import bmhpq_pkg::*;

  logic signed [KeyW-1:0] key_q, key_d;
  logic                   occupied;
  logic                   lt;

  // Slot holds a key when its position is below the element count
  assign occupied = (count_i > CW'(IDX));
  // New key goes at or before this slot
  assign lt = !occupied || (op_i.key < key_q);

  // Insert: take the new key at the boundary, shift right after it.
  // Extract: shift left by one.
  always_comb begin
    key_d = key_q;
    if (op_i.ins && lt) begin
      if (!prev_lt_i) begin
        key_d = op_i.key;
      end else begin
        key_d = prev_key_i;
      end
    end else if (op_i.ext) begin
      key_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;
  assign lt_o  = lt;

endmodule

// File: hw/rtl/binary_min_heap_priority_queue_core.sv
// Top level of the min-priority queue: sorted chain of key cells, element
// count, capacity register and the registered result stage.
// Depends on bmhpq_pkg and bmhpq_cell.
//
//   channel | direction | signals                                   | moves
//   --------+-----------+-------------------------------------------+------------------
//   in      | to core   | in_valid_i, in_ready_o, opcode_i, key_i   | one request
//   out     | from core | out_valid_o, out_ready_i, min_key_o,      | one result
//           |           | status_o, occupancy_o                     |
//   apb     | to core   | psel, penable, pwrite, paddr, ...         | capacity register
//
// Every request is processed in the cycle it is accepted: all cells compare
// against the broadcast key in parallel, so the result is valid in the next
// cycle and a new request can be accepted every cycle unless out is stalled.
// in_ready_o drops only while a result waits and out_ready_i is low.
// Reset empties the queue and sets capacity to 64; cells are not cleared.
module binary_min_heap_priority_queue_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              opcode_i,
  input  logic signed [bmhpq_pkg::KeyW-1:0] key_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [bmhpq_pkg::KeyW-1:0] min_key_o,
  output logic [1:0]                        status_o,
  output logic [bmhpq_pkg::OccW-1:0]        occupancy_o,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [1:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import bmhpq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > CapW) ? CW : CapW;

  // Capacity register
  logic [CapW-1:0] capacity_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == RegCapacityAddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapW'(64);
    end else if (cfg_wr) begin
      capacity_q <= pwdata[CapW-1:0];
    end
  end

  assign prdata = (paddr == RegCapacityAddr) ? {{(32 - CapW){1'b0}}, capacity_q} : 32'd0;

  // Handshake
  logic out_valid_q;
  logic accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Element count and limit check
  logic [CW-1:0] count_q, count_d;
  logic [LW-1:0] count_l;
  logic          full;
  logic          empty;

  assign count_l = LW'(count_q);
  assign full    = (count_l >= LW'(capacity_q)) || (count_l >= LW'(DEPTH));
  assign empty   = (count_q == '0);

  // Decode the request into a chain operation and a result
  bmhpq_op_t              op;
  logic signed [KeyW-1:0] key_w [DEPTH];
  logic                   lt_w  [DEPTH];
  bmhpq_status_e          status_d;
  logic signed [KeyW-1:0] min_key_d;

  always_comb begin
    op.ins    = 1'b0;
    op.ext    = 1'b0;
    op.key    = key_i;
    status_d  = ST_DONE;
    min_key_d = '0;
    count_d   = count_q;
    case (bmhpq_opcode_e'(opcode_i))
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          op.ins  = accept;
          count_d = count_q + CW'(1);
        end
      end
      OP_EXTRACT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          op.ext    = accept;
          min_key_d = key_w[0];
          count_d   = count_q - CW'(1);
        end
      end
      default: begin
        status_d = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // Sorted chain of cells, smallest key in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KeyW-1:0] prev_key;
    logic                   prev_lt;
    logic signed [KeyW-1:0] next_key;

    if (i == 0) begin : g_head
      assign prev_key = '0;
      assign prev_lt  = 1'b0;
    end else begin : g_body
      assign prev_key = key_w[i-1];
      assign prev_lt  = lt_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_key = '0;
    end else begin : g_link
      assign next_key = key_w[i+1];
    end

    bmhpq_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk_i      (clk_i),
      .op_i       (op),
      .count_i    (count_q),
      .prev_key_i (prev_key),
      .prev_lt_i  (prev_lt),
      .next_key_i (next_key),
      .key_o      (key_w[i]),
      .lt_o       (lt_w[i])
    );
  end

  // Result register
  logic signed [KeyW-1:0] min_key_q;
  logic [1:0]             status_q;
  logic [OccW-1:0]        occupancy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      min_key_q   <= min_key_d;
      status_q    <= status_d;
      occupancy_q <= OccW'(count_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign min_key_o   = min_key_q;
  assign status_o    = status_q;
  assign occupancy_o = occupancy_q;

`ifndef ASSERT_OFF
  // Count never runs past the cell chain
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW'(count_q) <= LW'(DEPTH))
    else $error("element count above DEPTH");

  // Every accepted request yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted request produced no result");

  // Head of the chain stays the smallest held key
  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (LW'(count_q) >= LW'(2)) |-> (key_w[0] <= key_w[1]))
    else $error("chain head out of order");

  // Count holds in any cycle without an accepted request
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("count changed without a request");
`endif

endmodule
